/* rtl/avs_pkg.sv */
package avs_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // shift the request value into the cell row
        logic restart;  // clear the step counter
        logic sort;     // one odd/even transposition round
        logic emit;     // shift the row down by one, toward the output
        logic clear;    // empty the store
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic at_last;  // step counter points at the last held value
    } t_status;

endpackage

/* rtl/ascending_value_sorter.sv */
// Collects one set of signed Q16.16 values, one per input request, into a row of
// MAX_ITEMS registers; values past MAX_ITEMS are dropped. The request marked
// final_item closes the set: the row is then sorted by n rounds of odd/even
// compare-exchange of neighboring cells (n = values held), and the values leave
// smallest first, one per cycle while the output is not stalled, with end_of_set
// on the largest. The input is stalled from the final request until the last value
// of the set has been taken.
module ascending_value_sorter #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_final_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_sorted_value,
    output logic               o_end_of_set
);
    import avs_pkg::*;

    t_cmd    cmd;
    t_status status;

    avs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_item (i_final_item),
        .i_out_stall  (i_out_stall),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid)
    );

    avs_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample_value (i_sample_value),
        .o_status       (status),
        .o_sorted_value (o_sorted_value)
    );

    assign o_end_of_set = status.at_last;

endmodule

/* rtl/avs_ctrl.sv */
module avs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_final_item,
    input  logic             i_out_stall,
    input  avs_pkg::t_status i_status,
    output avs_pkg::t_cmd    o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);
    import avs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   out_acc;

    // Handshakes decoded from state so the output block does not read its own outputs
    assign in_acc  = i_in_valid && (r_state == ST_LOAD);
    assign out_acc = (r_state == ST_EMIT) && !i_out_stall;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && i_final_item) begin
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                if (i_status.at_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_acc && i_status.at_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (in_acc) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.restart = i_final_item;
                end
            end
            ST_SORT: begin
                o_cmd.sort    = 1'b1;
                o_cmd.restart = i_status.at_last;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (out_acc) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.clear = i_status.at_last;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/avs_datapath.sv */
module avs_datapath #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  avs_pkg::t_cmd      i_cmd,
    input  logic signed [31:0] i_sample_value,
    output avs_pkg::t_status   o_status,
    output logic signed [31:0] o_sorted_value
);
    import avs_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = VALUE_BITS + 32;

    logic [VALUE_BITS-1:0] r_cell [MAX_ITEMS];
    logic [VALUE_BITS-1:0] n_cell [MAX_ITEMS];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_step;
    logic                  room;
    logic [VALUE_BITS-1:0] in_val;
    logic [XW-1:0]         in_wide;
    logic [XW-1:0]         out_wide;

    assign room = r_count < CW'(MAX_ITEMS);

    // Keep the low VALUE_BITS bits of the request value
    assign in_wide = XW'($unsigned(i_sample_value));
    assign in_val  = in_wide[VALUE_BITS-1:0];

    // The output always reads cell 0, which holds the next value to emit once the row is sorted
    assign out_wide       = XW'($signed(r_cell[0]));
    assign o_sorted_value = $signed(out_wide[31:0]);

    assign o_status.at_last = (r_step == (r_count - CW'(1)));

    // Cell row: shift in, odd/even compare-exchange, shift out
    always_comb begin
        n_cell = r_cell;
        if (i_cmd.load) begin
            if (room) begin
                for (int i = 1; i < MAX_ITEMS; i++) begin
                    n_cell[i] = r_cell[i-1];
                end
                n_cell[0] = in_val;
            end
        end else if (i_cmd.sort) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                if ((1'(i) == r_step[0]) && (CW'(i + 1) < r_count) &&
                    ($signed(r_cell[i]) > $signed(r_cell[i+1]))) begin
                    n_cell[i]   = r_cell[i+1];
                    n_cell[i+1] = r_cell[i];
                end
            end
        end else if (i_cmd.emit) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    // Fill count and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_step  <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.load && room) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.restart) begin
                r_step <= '0;
            end else if (i_cmd.sort || i_cmd.emit) begin
                r_step <= r_step + CW'(1);
            end
        end
    end

endmodule

/* rtl/avs_checker.sv */
module avs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic signed [31:0] i_sample_value,
    input logic               i_final_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_sorted_value,
    input logic               o_end_of_set
);

    // No new request is taken while results are still going out
    a_stall_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken during emission");

    // A final request closes the input side
    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_final_item) |=> o_in_stall)
        else $error("input still open after final request");

    // Last result of a set ends the emission
    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_end_of_set) |=> !o_out_valid)
        else $error("result after end of set");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_sorted_value) && $stable(o_end_of_set)))
        else $error("stalled result changed");

    // Stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=>
            (i_in_valid && $stable(i_sample_value) && $stable(i_final_item)))
        else $error("stalled request changed");

endmodule

bind ascending_value_sorter avs_checker u_avs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_sample_value (i_sample_value),
    .i_final_item   (i_final_item),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_sorted_value (o_sorted_value),
    .o_end_of_set   (o_end_of_set)
);

/* dv/ascending_value_sorter_checker.sv */
module ascending_value_sorter_checker #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_final_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_sorted_value,
    input  logic               i_end_of_set,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_sorted_result;

    // Shadow of the block's value row
    logic signed [VALUE_BITS-1:0] held_values [MAX_ITEMS];
    int                           held_count = 0;
    t_sorted_result               sorted_results [$];
    t_sorted_result               oldest;
    int                           fail_count   = 0;
    int                           result_count = 0;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
    end

    // Ascending signed bubble sort of the held set, then queue one result per value
    function automatic void queue_sorted_set();
        logic signed [VALUE_BITS-1:0] swap;
        t_sorted_result               r;
        for (int pass = 0; pass + 1 < held_count; pass++) begin
            for (int k = 0; k + 1 < held_count - pass; k++) begin
                if (held_values[k] > held_values[k + 1]) begin
                    swap               = held_values[k];
                    held_values[k]     = held_values[k + 1];
                    held_values[k + 1] = swap;
                end
            end
        end
        for (int k = 0; k < held_count; k++) begin
            r.value = 32'(held_values[k]);
            r.last  = (k == held_count - 1);
            sorted_results.push_back(r);
        end
        held_count = 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            sorted_results.delete();
        end else begin
            // compare each taken result with the oldest one predicted
            if (i_out_valid && !i_out_stall) begin
                result_count++;
                if (sorted_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, got value %0d end_of_set %0b",
                             $time, i_sorted_value, i_end_of_set);
                end else begin
                    oldest = sorted_results.pop_front();
                    if (i_sorted_value !== oldest.value) begin
                        fail_count++;
                        $display("%0t: sorted_value expected %0d, got %0d",
                                 $time, oldest.value, i_sorted_value);
                    end
                    if (i_end_of_set !== oldest.last) begin
                        fail_count++;
                        $display("%0t: end_of_set expected %0b, got %0b",
                                 $time, oldest.last, i_end_of_set);
                    end
                end
            end
            // accepted request: store if there is room, final one closes the set
            if (i_in_valid && !i_in_stall) begin
                if (held_count < MAX_ITEMS) begin
                    // the request word is zero-extended, then cut to VALUE_BITS
                    held_values[held_count] = VALUE_BITS'($unsigned(i_sample_value));
                    held_count++;
                end
                if (i_final_item)
                    queue_sorted_set();
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= sorted_results.size();
        o_result_count <= result_count;
    end

endmodule

/* dv/ascending_value_sorter_tb.sv */
module ascending_value_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS    = 64;
    localparam int VALUE_BITS   = 32;
    localparam int ITEM_TARGET  = 210;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 3 * MAX_ITEMS;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic signed [31:0] i_sample_value = '0;
    logic               i_final_item   = 1'b0;
    logic               i_out_stall    = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [31:0] o_sorted_value;
    logic               o_end_of_set;

    int fail_count;
    int pending;
    int result_count;
    int items_sent  = 0;
    int sets_sent   = 0;
    int cycle_count = 0;
    bit steady_run  = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    ascending_value_sorter #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_final_item   (i_final_item),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_value (o_sorted_value),
        .o_end_of_set   (o_end_of_set)
    );

    ascending_value_sorter_checker #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_final_item   (i_final_item),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_sorted_value (o_sorted_value),
        .i_end_of_set   (o_end_of_set),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Random backpressure on the sorted output
    always @(posedge i_clk) begin
        i_out_stall <= !steady_run && ($urandom_range(0, 99) < 20);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ascending_value_sorter_tb: errors");
            $finish;
        end
    end

    // One request; random idle cycles first, then hold until taken
    task automatic send_request(input logic signed [31:0] value, input logic last);
        while (!steady_run && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        i_final_item   <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Mix of full-range words, near-duplicates, extremes and plausible angles
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 15)) - 8;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sh0000_0000;
                    3: v = -32'sd1;
                    default: v = 32'sh0000_0001;
                endcase
            end
            default: v = (($signed($urandom_range(0, 720)) - 360) <<< 16)
                         + $signed($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    task automatic send_random_set(input int count);
        for (int k = 0; k < count; k++)
            send_request(pick_value(), k == count - 1);
        sets_sent++;
    endtask

    initial begin
        logic signed [31:0] extremes [7];
        logic signed [31:0] repeats [5];
        int                 set_size;

        extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sh1,
                     32'sh8000_0001, 32'sh7FFF_FFFE};
        repeats  = '{32'sd5, 32'sd5, -32'sd3, 32'sd5, -32'sd3};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-value set
        send_request(-32'sd98304, 1'b1);
        sets_sent++;
        // full-scale extremes, scrambled
        foreach (extremes[k])
            send_request(extremes[k], k == 6);
        sets_sent++;
        // equal values must all come out
        foreach (repeats[k])
            send_request(repeats[k], k == 4);
        sets_sent++;
        // reversed angles
        for (int k = 0; k < 8; k++)
            send_request((32'sd4 - k) <<< 16, k == 7);
        sets_sent++;
        // already ascending
        for (int k = 0; k < 4; k++)
            send_request(32'sd100 * k - 32'sd150, k == 3);
        sets_sent++;

        // overflowing set: final value lands on a full store and is dropped
        send_random_set(MAX_ITEMS + 2);

        // random sets, mostly small; a burst without any idling in the middle
        while (items_sent < ITEM_TARGET) begin
            steady_run = (items_sent >= 110 && items_sent < 160);
            if ($urandom_range(0, 11) == 0)
                set_size = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 4);
            else
                set_size = $urandom_range(1, 10);
            send_random_set(set_size);
        end
        steady_run = 1'b0;
        i_in_valid <= 1'b0;

        // let the last prediction land, then drain
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sorted %0d sets from %0d requests, %0d results checked", sets_sent,
                 items_sent, result_count);
        $display("Covered single values, extremes, duplicates and sets past capacity");
        if (fail_count == 0)
            $display("ascending_value_sorter_tb: clean");
        else
            $display("ascending_value_sorter_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/avs_pkg.sv
rtl/avs_ctrl.sv
rtl/avs_datapath.sv
rtl/ascending_value_sorter.sv
rtl/avs_checker.sv
dv/ascending_value_sorter_checker.sv
dv/ascending_value_sorter_tb.sv
